// File: hw/rtl/ekms_pkg.sv
// Shared types and constants for the event key match search unit.
`timescale 1ns / 1ps

package ekms_pkg;

  localparam int TABLE_DEPTH   = 1024;
  localparam int IDX_W         = $clog2(TABLE_DEPTH);
  localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
  localparam int MATCH_INDEX_W = 10;
  localparam int STATUS_W      = 3;
  localparam int CMD_W         = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_LOADED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MATCH   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISS    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

  typedef struct packed {
    logic [31:0] run;
    logic [31:0] lumi;
    logic [63:0] event_num;
  } key_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    key_t             key;
  } tbl_wr_req_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } tbl_rd_req_t;

endpackage

// File: hw/rtl/ekms_table.sv
// Key table storage: one write port and one registered read port.
`timescale 1ns / 1ps

module ekms_table (
  input  logic                 clk,
  input  ekms_pkg::tbl_wr_req_t wr_req,
  input  ekms_pkg::tbl_rd_req_t rd_req,
  output ekms_pkg::key_t       rd_key_r
);
  import ekms_pkg::*;

  key_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      mem[wr_req.addr] <= wr_req.key;
    end
    if (rd_req.en) begin
      rd_key_r <= mem[rd_req.addr];
    end
  end

endmodule

// File: hw/rtl/event_key_match_search_unit.sv
// Top level of the event key match search unit: sequencer, hint and result register.
`timescale 1ns / 1ps
//
//  Channel  Direction  Handshake          Payload
//  in_      input      in_valid/in_stall   cmd, key_run, key_lumi, key_event
//  out_     output     out_valid/out_stall status, match_index
//
//  Load, clear and unknown commands are answered on acceptance. A search walks
//  the table one entry per cycle through the table's single read port, from the hint
//  onwards, until a hit or until every entry has been compared without one.
//  Reset empties the table and the hint at once; table contents need no clearing.
//  A result waits in the output register while out_stall is high; a new item is
//  taken only when that register is free or being emptied.

module event_key_match_search_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ekms_pkg::CMD_W-1:0]         in_cmd,
  input  logic [31:0]                       in_key_run,
  input  logic [31:0]                       in_key_lumi,
  input  logic [63:0]                       in_key_event,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ekms_pkg::STATUS_W-1:0]      out_status,
  output logic [ekms_pkg::MATCH_INDEX_W-1:0] out_match_index
);
  import ekms_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_DONE   = 2'd2;

  logic [1:0]               state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [IDX_W-1:0]         start_r, start_nxt;
  logic [IDX_W-1:0]         rd_addr_r, rd_addr_nxt;
  logic [CNT_W-1:0]         iss_r, iss_nxt;
  logic                     rd_vld_r, rd_vld_nxt;
  logic                     rd_last_r, rd_last_nxt;
  logic [IDX_W-1:0]         rd_idx_r;
  key_t                     q_key_r, q_key_nxt;
  logic [STATUS_W-1:0]      res_status_r, res_status_nxt;
  logic [IDX_W-1:0]         res_index_r, res_index_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]      out_status_r, out_status_nxt;
  logic [MATCH_INDEX_W-1:0] out_index_r, out_index_nxt;

  tbl_wr_req_t wr_req;
  tbl_rd_req_t rd_req;
  key_t        rd_key_r;
  key_t        in_key;
  logic        accept;
  logic        out_free;
  logic        issue;
  logic [IDX_W-1:0] first_idx;
  logic [IDX_W-1:0] last_idx;

  ekms_table u_table (
    .clk      (clk),
    .wr_req   (wr_req),
    .rd_req   (rd_req),
    .rd_key_r (rd_key_r)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !out_free;
  assign accept    = in_valid && !in_stall;
  assign in_key    = '{run: in_key_run, lumi: in_key_lumi, event_num: in_key_event};
  assign last_idx  = IDX_W'(count_r - CNT_W'(1));
  // The hint never exceeds the entry count, so reducing it modulo the count
  // only has to fold the case where they are equal.
  assign first_idx = ({1'b0, start_r} >= count_r) ? '0 : start_r;
  assign issue     = (state_r == S_SEARCH) && (iss_r < count_r);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    start_nxt      = start_r;
    rd_addr_nxt    = rd_addr_r;
    iss_nxt        = iss_r;
    q_key_nxt      = q_key_r;
    res_status_nxt = res_status_r;
    res_index_nxt  = res_index_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    rd_vld_nxt     = issue;
    rd_last_nxt    = (iss_r == count_r - CNT_W'(1));
    wr_req         = '{en: 1'b0, addr: IDX_W'(count_r), key: in_key};
    rd_req         = '{en: issue, addr: rd_addr_r};

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_LOAD: begin
              out_valid_nxt = 1'b1;
              if (count_r < CNT_W'(TABLE_DEPTH)) begin
                wr_req.en      = 1'b1;
                count_nxt      = count_r + CNT_W'(1);
                out_status_nxt = ST_LOADED;
                out_index_nxt  = MATCH_INDEX_W'(count_r);
              end else begin
                out_status_nxt = ST_FULL;
                out_index_nxt  = '0;
              end
            end
            CMD_SEARCH: begin
              if (count_r == '0) begin
                start_nxt      = '0;
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_MISS;
                out_index_nxt  = '0;
              end else begin
                q_key_nxt   = in_key;
                rd_addr_nxt = first_idx;
                iss_nxt     = '0;
                state_nxt   = S_SEARCH;
              end
            end
            CMD_CLEAR: begin
              count_nxt      = '0;
              start_nxt      = '0;
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_CLEARED;
              out_index_nxt  = '0;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_MISS;
              out_index_nxt  = '0;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (issue) begin
          iss_nxt     = iss_r + CNT_W'(1);
          rd_addr_nxt = (rd_addr_r == last_idx) ? '0 : rd_addr_r + IDX_W'(1);
        end
        // The entry read in the previous cycle is compared here.
        if (rd_vld_r) begin
          if (rd_key_r == q_key_r) begin
            res_status_nxt = ST_MATCH;
            res_index_nxt  = rd_idx_r;
            start_nxt      = (rd_idx_r == IDX_W'(TABLE_DEPTH - 1)) ? '0
                                                                 : rd_idx_r + IDX_W'(1);
            state_nxt      = S_DONE;
          end else if (rd_last_r) begin
            res_status_nxt = ST_MISS;
            res_index_nxt  = '0;
            start_nxt      = '0;
            state_nxt      = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_index_nxt  = MATCH_INDEX_W'(res_index_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      start_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      start_r     <= start_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r    <= rd_addr_nxt;
    iss_r        <= iss_nxt;
    rd_last_r    <= rd_last_nxt;
    rd_idx_r     <= rd_addr_r;
    q_key_r      <= q_key_nxt;
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_match_index = out_index_r;

endmodule

// File: sim/ekms_answer_checker.sv
// Checker that predicts and compares the answers of the event key match search unit.
`timescale 1ns / 1ps

module ekms_answer_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [ekms_pkg::CMD_W-1:0]         in_cmd,
  input  logic [31:0]                       in_key_run,
  input  logic [31:0]                       in_key_lumi,
  input  logic [63:0]                       in_key_event,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [ekms_pkg::STATUS_W-1:0]      out_status,
  input  logic [ekms_pkg::MATCH_INDEX_W-1:0] out_match_index,
  output int unsigned                       pending_answers,
  output int unsigned                       wrong_answers
);
  import ekms_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [MATCH_INDEX_W-1:0] index;
  } answer_t;

  key_t    key_store [TABLE_DEPTH];
  int      loaded_count;
  int      hint_slot;
  answer_t answers_due [$];

  function automatic answer_t table_answer(input logic [CMD_W-1:0] cmd, input key_t key);
    answer_t a;
    int      slot;
    int      n;
    bit      found;
    a.status = ST_MISS;
    a.index  = '0;
    slot     = 0;
    found    = 1'b0;
    case (cmd)
      CMD_LOAD: begin
        if (loaded_count < TABLE_DEPTH) begin
          key_store[loaded_count] = key;
          a.status = ST_LOADED;
          a.index  = loaded_count[MATCH_INDEX_W-1:0];
          loaded_count++;
        end else begin
          a.status = ST_FULL;
        end
      end
      CMD_SEARCH: begin
        // The walk starts at the hint reduced by the current fill level and wraps once.
        if (loaded_count > 0) begin
          slot = hint_slot % loaded_count;
          for (n = 0; n < loaded_count && !found; n++) begin
            if (key_store[slot] == key) found = 1'b1;
            else if (slot + 1 >= loaded_count) slot = 0;
            else slot++;
          end
        end
        if (found) begin
          a.status  = ST_MATCH;
          a.index   = slot[MATCH_INDEX_W-1:0];
          hint_slot = (slot + 1) % TABLE_DEPTH;
        end else begin
          a.status  = ST_MISS;
          hint_slot = 0;
        end
      end
      CMD_CLEAR: begin
        loaded_count = 0;
        hint_slot    = 0;
        a.status     = ST_CLEARED;
      end
      default: begin
        // An unknown command leaves the table alone and reports a miss.
      end
    endcase
    return a;
  endfunction

  task automatic note_wrong(input answer_t want, input answer_t got, input bit unexpected);
    if (wrong_answers < 10) begin
      if (unexpected)
        $display("%0t: answer with nothing due: status %0d index %0d",
                 $time, got.status, got.index);
      else
        $display("%0t: wrong answer: status %0d index %0d, expected status %0d index %0d",
                 $time, got.status, got.index, want.status, want.index);
    end
    wrong_answers++;
  endtask

  always @(posedge clk) begin : watch
    answer_t got;
    answer_t want;
    if (!rst_n) begin
      loaded_count = 0;
      hint_slot    = 0;
      wrong_answers = 0;
      answers_due.delete();
      pending_answers <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.status = out_status;
        got.index  = out_match_index;
        if (answers_due.size() == 0) begin
          note_wrong(got, got, 1'b1);
        end else begin
          want = answers_due.pop_front();
          if (got.status !== want.status || got.index !== want.index)
            note_wrong(want, got, 1'b0);
        end
      end
      if (in_valid && !in_stall)
        answers_due = {answers_due,
                       table_answer(in_cmd, {in_key_run, in_key_lumi, in_key_event})};
      pending_answers <= answers_due.size();
    end
  end

endmodule

// File: sim/tb_top.sv
// Testbench top for the event key match search unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import ekms_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam int ITEM_TARGET  = 1150;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 1100;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [CMD_W-1:0]         in_cmd;
  logic [31:0]              in_key_run;
  logic [31:0]              in_key_lumi;
  logic [63:0]              in_key_event;
  logic                     out_valid;
  logic                     out_stall;
  logic [STATUS_W-1:0]      out_status;
  logic [MATCH_INDEX_W-1:0] out_match_index;
  int unsigned              pending_answers;
  int unsigned              wrong_answers;

  logic  hold_go;
  bit    steady;
  int    burst_left;
  int    sent_items;
  int    walk_pos;
  key_t  loaded_keys [$];

  event_key_match_search_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_key_run      (in_key_run),
    .in_key_lumi     (in_key_lumi),
    .in_key_event    (in_key_event),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_match_index (out_match_index)
  );

  ekms_answer_checker CHECK (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_key_run      (in_key_run),
    .in_key_lumi     (in_key_lumi),
    .in_key_event    (in_key_event),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_match_index (out_match_index),
    .pending_answers (pending_answers),
    .wrong_answers   (wrong_answers)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic key_t random_key();
    key_t k;
    k.run       = $urandom;
    k.lumi      = $urandom;
    k.event_num = {$urandom, $urandom};
    return k;
  endfunction

  // New keys repeat an already loaded key now and then, so that searches see duplicates.
  function automatic key_t fresh_key();
    if (loaded_keys.size() != 0 && $urandom_range(0, 4) == 0)
      return loaded_keys[$urandom_range(0, loaded_keys.size() - 1)];
    return random_key();
  endfunction

  task automatic hold_back(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic offer(input logic [CMD_W-1:0] cmd, input key_t key);
    if (!steady && burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) hold_back($urandom_range(1, 12));
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_key_run   <= key.run;
    in_key_lumi  <= key.lumi;
    in_key_event <= key.event_num;
    do @(posedge clk); while (in_stall);
    sent_items++;
    if (cmd == CMD_LOAD && loaded_keys.size() < TABLE_DEPTH) loaded_keys = {loaded_keys, key};
    if (cmd == CMD_CLEAR) begin
      loaded_keys.delete();
      walk_pos = 0;
    end
  endtask

  task automatic run_episode(input bit fill_table, input bit long_hold);
    int   loads;
    int   searches;
    int   pick;
    int   i;
    key_t k;
    steady = long_hold || ($urandom_range(0, 3) == 0);
    if (long_hold) hold_go = 1'b1;
    if (fill_table || $urandom_range(0, 4) != 0) offer(CMD_CLEAR, random_key());
    loads = fill_table ? TABLE_DEPTH - loaded_keys.size() + 3 : $urandom_range(0, 24);
    if (long_hold) loads = 16;
    for (i = 0; i < loads; i++) begin
      // The last slot of a full table gets a unique key so that the hint wraps on its hit.
      if (fill_table && loaded_keys.size() == TABLE_DEPTH - 1) offer(CMD_LOAD, random_key());
      else offer(CMD_LOAD, fresh_key());
    end
    searches = fill_table ? 40 : $urandom_range(2, 30);
    if (fill_table) begin
      offer(CMD_SEARCH, loaded_keys[TABLE_DEPTH - 1]);
      offer(CMD_SEARCH, loaded_keys[0]);
    end
    for (i = 0; i < searches; i++) begin
      pick = $urandom_range(0, 99);
      if (loaded_keys.size() == 0 && pick < 84) begin
        offer(CMD_SEARCH, random_key());
      end else if (pick < 60) begin
        walk_pos = (walk_pos + $urandom_range(0, 3)) % loaded_keys.size();
        offer(CMD_SEARCH, loaded_keys[walk_pos]);
      end else if (pick < 72) begin
        offer(CMD_SEARCH, loaded_keys[$urandom_range(0, loaded_keys.size() - 1)]);
      end else if (pick < 84) begin
        k = loaded_keys[$urandom_range(0, loaded_keys.size() - 1)];
        pick = $urandom_range(0, 127);
        k[pick] = ~k[pick];
        offer(CMD_SEARCH, k);
      end else if (pick < 90) begin
        offer(CMD_SEARCH, random_key());
      end else if (pick < 95) begin
        offer(CMD_LOAD, fresh_key());
      end else if (pick < 98) begin
        offer(CMD_UNKNOWN, random_key());
      end else begin
        offer(CMD_CLEAR, random_key());
      end
    end
  endtask

  // The receiver stalls at a rate that changes now and then, and once holds off for a long time.
  initial begin : receiver
    int stall_pct;
    int cycle_no;
    bit hold_done;
    out_stall = 1'b0;
    stall_pct = 0;
    cycle_no  = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        if (cycle_no % 96 == 0) begin
          case ($urandom_range(0, 4))
            0, 1:    stall_pct = 0;
            2:       stall_pct = 15;
            3:       stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
        cycle_no++;
      end
    end
  end

  initial begin : stimulus
    key_t zero_key;
    key_t ones_key;
    key_t run_max_key;
    key_t mixed_key;
    int   episode;
    zero_key    = '0;
    ones_key    = '1;
    run_max_key = {32'hFFFF_FFFF, 32'h0, 64'h0};
    mixed_key   = {32'h8000_0001, 32'h5555_AAAA, 64'h0123_4567_89AB_CDEF};
    in_valid     = 1'b0;
    in_cmd       = CMD_LOAD;
    in_key_run   = '0;
    in_key_lumi  = '0;
    in_key_event = '0;
    rst_n        = 1'b0;
    hold_go      = 1'b0;
    steady       = 1'b0;
    burst_left   = 0;
    sent_items   = 0;
    walk_pos     = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    offer(CMD_SEARCH, zero_key);             // empty table
    offer(CMD_UNKNOWN, ones_key);
    offer(CMD_LOAD, zero_key);
    offer(CMD_LOAD, ones_key);
    offer(CMD_LOAD, run_max_key);
    offer(CMD_LOAD, zero_key);               // duplicate of the first slot
    offer(CMD_SEARCH, zero_key);
    offer(CMD_SEARCH, zero_key);             // found past the hint, not at slot zero
    offer(CMD_SEARCH, zero_key);             // hint equals the fill level and wraps to zero
    offer(CMD_SEARCH, ones_key);
    offer(CMD_SEARCH, ones_key ^ 128'h1);    // differs in the lowest event bit
    offer(CMD_SEARCH, ones_key ^ (128'h1 << 95));
    offer(CMD_SEARCH, run_max_key);
    offer(CMD_LOAD, mixed_key);              // a load keeps the hint
    offer(CMD_SEARCH, zero_key);
    offer(CMD_UNKNOWN, ones_key);
    offer(CMD_SEARCH, ones_key);
    offer(CMD_CLEAR, ones_key);
    offer(CMD_SEARCH, ones_key);
    offer(CMD_LOAD, ones_key);
    offer(CMD_SEARCH, ones_key);

    episode = 0;
    while (sent_items < ITEM_TARGET) begin
      run_episode(episode == 2, episode == 1);
      episode++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_answers != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (wrong_answers == 0)
      $display("event_key_match_search_unit: match");
    else
      $display("event_key_match_search_unit: mismatch");
    $finish;
  end

  initial begin : watchdog
    #60_000_000;
    $display("event_key_match_search_unit: mismatch");
    $finish;
  end

endmodule
